### design/positional_list_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Clocked property wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, off during reset
`define PLE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define PLE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset as well
`define PLE_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ple_pkg.sv
// ---------------------------------------------------------------------------
// Positional list engine package
// Field widths, command and status codes, and controller/datapath types.
// ---------------------------------------------------------------------------
package ple_pkg;

   localparam int VW = 32;
   localparam int PW = 6;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADPOS = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   typedef enum logic [1:0] {
      DP_HOLD,
      DP_EXEC,
      DP_FIRST,
      DP_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic read_multi;
      logic single_entry;
      logic at_last;
   } dp_stat_type;

endpackage

### design/ple_datapath.sv
// ---------------------------------------------------------------------------
// Positional list engine datapath
// Shifting cell row, entry count, read out index and response registers.
// ---------------------------------------------------------------------------
module ple_datapath
   import ple_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_cmd,
   input  logic [PW-1:0]        req_position,
   input  logic signed [VW-1:0] req_item_value,
   input  dp_cmd_type           dp_cmd,
   output dp_stat_type          dp_stat,
   output logic signed [VW-1:0] rsp_result_value,
   output logic [1:0]           rsp_status,
   output logic [PW-1:0]        rsp_list_length,
   output logic                 rsp_last_of_run
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > PW) ? CW : PW) + 1;

   logic [VW-1:0] cell_ff [CAPACITY];
   logic [VW-1:0] cell_in [CAPACITY];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in, idx_cur;
   logic [XW-1:0] count_x, pos_x, slot_x;
   logic          full, do_insert, do_delete, do_rotate;
   status_type    exec_status;

   logic [VW-1:0] value_ff, value_in;
   status_type    status_ff, status_in;
   logic [PW-1:0] length_ff, length_in;
   logic          last_ff, last_in;

   assign full      = (count_ff == CW'(CAPACITY));
   assign count_x   = XW'(count_ff);
   assign pos_x     = XW'(req_position);
   assign do_rotate = (dp_cmd.op == DP_FIRST) || (dp_cmd.op == DP_NEXT);
   assign idx_cur   = (dp_cmd.op == DP_FIRST) ? '0 : idx_ff;

   always_comb begin
      do_insert   = 1'b0;
      do_delete   = 1'b0;
      slot_x      = count_x;
      exec_status = ST_OK;
      case (cmd_type'(req_cmd))
         CMD_APPEND: begin
            if (full) exec_status = ST_FULL;
            else do_insert = 1'b1;
         end
         CMD_INSERT: begin
            if (full) begin
               exec_status = ST_FULL;
            end else if (pos_x == '0) begin
               exec_status = ST_BADPOS;
            end else begin
               do_insert = 1'b1;
               if ((pos_x - XW'(1)) < count_x) slot_x = pos_x - XW'(1);
            end
         end
         CMD_DELETE: begin
            slot_x = pos_x - XW'(1);
            if (count_ff == '0) exec_status = ST_EMPTY;
            else if (pos_x == '0 || pos_x > count_x) exec_status = ST_BADPOS;
            else do_delete = 1'b1;
         end
         CMD_READ: exec_status = ST_EMPTY;
         default: exec_status = ST_OK;
      endcase
      if (dp_cmd.op != DP_EXEC) begin
         do_insert = 1'b0;
         do_delete = 1'b0;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VW-1:0] lower, upper;
      logic [XW-1:0] pos_i;
      if (i > 0) begin : g_lower
         assign lower = cell_ff[i-1];
      end else begin : g_lower0
         assign lower = '0;
      end
      if (i < CAPACITY - 1) begin : g_upper
         assign upper = cell_ff[i+1];
      end else begin : g_upper0
         assign upper = '0;
      end
      assign pos_i = XW'(i);
      always_comb begin
         cell_in[i] = cell_ff[i];
         if (do_insert) begin
            if (pos_i == slot_x) cell_in[i] = req_item_value;
            else if (pos_i > slot_x && pos_i <= count_x) cell_in[i] = lower;
         end else if (do_delete) begin
            if (pos_i >= slot_x && (pos_i + XW'(1)) < count_x) cell_in[i] = upper;
         end else if (do_rotate) begin
            if ((pos_i + XW'(1)) < count_x) cell_in[i] = upper;
            else if ((pos_i + XW'(1)) == count_x) cell_in[i] = cell_ff[0];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) count_in = count_ff + CW'(1);
      else if (do_delete) count_in = count_ff - CW'(1);
      idx_in    = do_rotate ? idx_cur + CW'(1) : idx_ff;
      value_in  = value_ff;
      status_in = status_ff;
      length_in = length_ff;
      last_in   = last_ff;
      if (dp_cmd.op == DP_EXEC) begin
         value_in  = '0;
         status_in = exec_status;
         length_in = PW'(count_in);
         last_in   = 1'b1;
      end else if (do_rotate) begin
         value_in  = cell_ff[0];
         status_in = ST_OK;
         length_in = PW'(count_ff);
         last_in   = ((idx_cur + CW'(1)) == count_ff);
      end
   end

   always_ff @(posedge clock) begin
      cell_ff   <= cell_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      length_ff <= length_in;
      last_ff   <= last_in;
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign dp_stat.read_multi   = (cmd_type'(req_cmd) == CMD_READ) && (count_ff != '0);
   assign dp_stat.single_entry = (count_ff == CW'(1));
   assign dp_stat.at_last      = ((idx_ff + CW'(1)) == count_ff);

   assign rsp_result_value = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_list_length  = length_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

### design/ple_controller.sv
// ---------------------------------------------------------------------------
// Positional list engine controller
// Sequences commands and read out, and owns both channel handshakes.
// ---------------------------------------------------------------------------
module ple_controller
   import ple_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      dp_cmd.op    = DP_HOLD;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            req_stall = !can_load;
            if (req_valid && can_load) begin
               rsp_valid_in = 1'b1;
               if (dp_stat.read_multi) begin
                  dp_cmd.op = DP_FIRST;
                  if (!dp_stat.single_entry) state_in = S_READ;
               end else begin
                  dp_cmd.op = DP_EXEC;
               end
            end
         end
         S_READ: begin
            if (can_load) begin
               dp_cmd.op    = DP_NEXT;
               rsp_valid_in = 1'b1;
               if (dp_stat.at_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/positional_list_engine.sv
// ---------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with append, insert, delete, read out.
// ---------------------------------------------------------------------------
// A request beat carries req_cmd, req_position (1-based) and req_item_value.
// Append, insert and delete each give one response beat with status and the
// new list length; read out gives one beat per stored entry, first to last,
// with rsp_last_of_run on the final one (an empty list gives one beat with
// the empty status).
// The first response beat is registered in the cycle after the request
// beat. The cell row shifts by one place for append, insert and delete,
// so the engine can take a new request after each of them; read out
// steps through the entries by rotating the cell row through its head
// cell, and no request is taken meanwhile.
// Reset empties the list at once; no clearing pass is needed.
// When the receiver stalls, the response register holds its beat, read out
// pauses, and req_stall rises until the held beat is taken.
// ---------------------------------------------------------------------------
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [PW-1:0]        req_position,
   input  logic signed [VW-1:0] req_item_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [VW-1:0] rsp_result_value,
   output logic [1:0]           rsp_status,
   output logic [PW-1:0]        rsp_list_length,
   output logic                 rsp_last_of_run
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   ple_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_position     (req_position),
      .req_item_value   (req_item_value),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_list_length  (rsp_list_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

### design/ple_checker.sv
// ---------------------------------------------------------------------------
// Positional list engine checker
// Port-level properties of the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module ple_checker
   import ple_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic signed [VW-1:0] rsp_result_value,
   input logic [1:0]           rsp_status,
   input logic [PW-1:0]        rsp_list_length,
   input logic                 rsp_last_of_run
);

   `PLE_ASSERT_RST(a_reset_idle, reset, !rsp_valid, "response beat right after reset")

   `PLE_ASSERT_NXT(a_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_value) && $stable(rsp_status)
      && $stable(rsp_last_of_run), "stalled beat changed")

   `PLE_ASSERT_IMP(a_error_single, rsp_valid && (rsp_status != ST_OK),
      rsp_last_of_run && (rsp_result_value == '0), "error beat not single or nonzero value")

   `PLE_ASSERT_IMP(a_empty_len, rsp_valid && (rsp_status == ST_EMPTY),
      rsp_list_length == '0, "empty status with nonzero length")

endmodule

bind positional_list_engine ple_checker u_chk (.*);
